/* design/assert_macros.svh */
// Assertion macros used by the range extreme core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* design/ctre_pkg.sv */
// Types and constants of the Cartesian tree range extreme block
`timescale 1ns / 1ps
`default_nettype none
package ctre_pkg;
	localparam int CAPACITY_DEF   = 1024;
	localparam int VALUE_BITS_DEF = 32;

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_QUERY  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [1:0] STS_DONE     = 2'd0;
	localparam logic [1:0] STS_NOTFOUND = 2'd1;
	localparam logic [1:0] STS_FULL     = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] new_value;
		logic [9:0]         range_low;
		logic [9:0]         range_high;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] result_value;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP_RD,
		S_POP_CMP,
		S_WALK,
		S_QVAL,
		S_RESULT
	} state_t;
endpackage
`default_nettype wire

/* design/cartesian_tree_range_extreme_core.sv */
// Cartesian tree for range minimum or maximum queries over appended values
// Usage:
//   Commands enter on cmd_valid/cmd_stall with cmd_item; one response per
//   command leaves on rsp_valid/rsp_stall with rsp_item. A transfer happens
//   when valid is high and stall is low. cfg_we/cfg_wdata write keep_maximum
//   and may only be used while the block is idle.
//   Flow: one command is in work at a time. Clear, unused codes and a
//   full append go straight from idle to the result state.
//   Append runs the pop loop over each spine entry examined (the pop loop
//   reads the spine stack, then the node value of its top).
//   Query walks the tree level by level until a node in range is found or
//   the walk leaves the tree; its worst case is set by tree depth.
//   The response register frees the input side: the next command is taken
//   the cycle after the previous one has placed its response, even if that
//   response is still stalled, but not before that response is placed.
//   A stalled response holds until taken.
//   Reset empties the tree and clears keep_maximum; memories are not
//   cleared, since every entry is written before it is read.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cartesian_tree_range_extreme_core #(
	parameter int CAPACITY   = ctre_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = ctre_pkg::VALUE_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_wdata,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire ctre_pkg::in_item_t  cmd_item,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output ctre_pkg::out_item_t      rsp_item
);
	import ctre_pkg::*;

	localparam int IW   = $clog2(CAPACITY);
	localparam int LW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (LW > 10) ? LW : 10;
	localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);

	state_t state_q, state_d;

	logic            keep_max_q;
	logic [LW-1:0]   depth_q, count_q, root_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [9:0]      lo_q, hi_q;
	logic [IW-1:0]   t_q;
	logic            dir_q;
	out_item_t       res_q, rsp_q;
	logic            rsp_valid_q;

	// memory ports
	logic                  nv_we, nv_re, ll_we, ll_re, rl_we, rl_re, sp_we, sp_re;
	logic [IW-1:0]         nv_waddr, nv_raddr, ll_waddr, ll_raddr;
	logic [IW-1:0]         rl_waddr, rl_raddr, sp_waddr, sp_raddr;
	logic [VALUE_BITS-1:0] nv_wdata, nv_rdata;
	logic [LW-1:0]         ll_wdata, ll_rdata, rl_wdata, rl_rdata;
	logic [IW-1:0]         sp_wdata, sp_rdata;

	ctre_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_node_values (
		.clk(clk), .we(nv_we), .waddr(nv_waddr), .wdata(nv_wdata),
		.re(nv_re), .raddr(nv_raddr), .rdata(nv_rdata));
	ctre_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_left_links (
		.clk(clk), .we(ll_we), .waddr(ll_waddr), .wdata(ll_wdata),
		.re(ll_re), .raddr(ll_raddr), .rdata(ll_rdata));
	ctre_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_right_links (
		.clk(clk), .we(rl_we), .waddr(rl_waddr), .wdata(rl_wdata),
		.re(rl_re), .raddr(rl_raddr), .rdata(rl_rdata));
	ctre_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_spine_stack (
		.clk(clk), .we(sp_we), .waddr(sp_waddr), .wdata(sp_wdata),
		.re(sp_re), .raddr(sp_raddr), .rdata(sp_rdata));

	// shared conditions
	logic                  cmd_fire, is_full, top_better, res_free;
	logic [VALUE_BITS-1:0] in_value;
	logic [LW-1:0]         p_cur, depth_m1, depth_m2;
	logic [9:0]            range_lo, range_hi;
	logic                  p_valid, go_right, go_left;

	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign is_full   = (count_q == NULL_LINK);
	assign in_value  = VALUE_BITS'(cmd_item.new_value);
	assign depth_m1  = depth_q - LW'(1);
	assign depth_m2  = depth_q - LW'(2);
	assign res_free  = !rsp_valid_q || !rsp_stall;
	assign top_better = keep_max_q ? ($signed(nv_rdata) > $signed(value_q))
	                               : ($signed(nv_rdata) < $signed(value_q));

	assign p_cur    = (state_q == S_WALK) ? (dir_q ? rl_rdata : ll_rdata) : root_q;
	assign range_lo = (state_q == S_IDLE) ? cmd_item.range_low : lo_q;
	assign range_hi = (state_q == S_IDLE) ? cmd_item.range_high : hi_q;
	assign p_valid  = (p_cur < count_q);
	assign go_right = (CMPW'(p_cur) < CMPW'(range_lo));
	assign go_left  = (CMPW'(range_hi) < CMPW'(p_cur));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					state_d = S_RESULT;
					if (cmd_item.command == CMD_APPEND && !is_full && depth_q != '0) begin
						state_d = S_POP_RD;
					end else if (cmd_item.command == CMD_QUERY && p_valid) begin
						state_d = (go_right || go_left) ? S_WALK : S_QVAL;
					end
				end
			end
			S_POP_RD: state_d = S_POP_CMP;
			S_POP_CMP: begin
				if (top_better || depth_q == LW'(1)) begin
					state_d = S_RESULT;
				end else begin
					state_d = S_POP_RD;
				end
			end
			S_WALK: begin
				if (!p_valid) begin
					state_d = S_RESULT;
				end else if (!go_right && !go_left) begin
					state_d = S_QVAL;
				end
			end
			S_QVAL: state_d = S_RESULT;
			S_RESULT: begin
				if (res_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		nv_we = 1'b0; nv_re = 1'b0; ll_we = 1'b0; ll_re = 1'b0;
		rl_we = 1'b0; rl_re = 1'b0; sp_we = 1'b0; sp_re = 1'b0;
		nv_waddr = count_q[IW-1:0];
		nv_wdata = in_value;
		nv_raddr = p_cur[IW-1:0];
		ll_waddr = count_q[IW-1:0];
		ll_wdata = root_q;
		ll_raddr = p_cur[IW-1:0];
		rl_waddr = count_q[IW-1:0];
		rl_wdata = NULL_LINK;
		rl_raddr = p_cur[IW-1:0];
		sp_waddr = '0;
		sp_wdata = count_q[IW-1:0];
		sp_raddr = depth_m1[IW-1:0];
		case (state_q)
			S_IDLE: begin
				if (cmd_fire && cmd_item.command == CMD_APPEND && !is_full) begin
					nv_we = 1'b1;
					rl_we = 1'b1;
					if (depth_q == '0) begin
						ll_we = 1'b1;
						sp_we = 1'b1;
					end else begin
						sp_re = 1'b1;
					end
				end else if (cmd_fire && cmd_item.command == CMD_QUERY && p_valid) begin
					rl_re = go_right;
					ll_re = !go_right && go_left;
					nv_re = !go_right && !go_left;
				end
			end
			S_POP_RD: begin
				nv_re    = 1'b1;
				rl_re    = 1'b1;
				nv_raddr = sp_rdata;
				rl_raddr = sp_rdata;
			end
			S_POP_CMP: begin
				if (top_better) begin
					// hang the popped subtree under the new node
					ll_we    = 1'b1;
					ll_wdata = rl_rdata;
					rl_we    = 1'b1;
					rl_waddr = t_q;
					rl_wdata = count_q;
					sp_we    = 1'b1;
					sp_waddr = depth_q[IW-1:0];
				end else if (depth_q == LW'(1)) begin
					ll_we = 1'b1;
					sp_we = 1'b1;
				end else begin
					sp_re    = 1'b1;
					sp_raddr = depth_m2[IW-1:0];
				end
			end
			S_WALK: begin
				if (p_valid) begin
					rl_re = go_right;
					ll_re = !go_right && go_left;
					nv_re = !go_right && !go_left;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			keep_max_q  <= 1'b0;
			depth_q     <= '0;
			count_q     <= '0;
			root_q      <= NULL_LINK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				keep_max_q <= cfg_wdata;
			end
			if (state_q == S_RESULT && res_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_fire && cmd_item.command == CMD_CLEAR) begin
						depth_q <= '0;
						count_q <= '0;
						root_q  <= NULL_LINK;
					end else if (cmd_fire && cmd_item.command == CMD_APPEND && !is_full
					             && depth_q == '0) begin
						depth_q <= LW'(1);
						count_q <= count_q + LW'(1);
						root_q  <= count_q;
					end
				end
				S_POP_CMP: begin
					if (top_better) begin
						depth_q <= depth_q + LW'(1);
						count_q <= count_q + LW'(1);
					end else if (depth_q == LW'(1)) begin
						count_q <= count_q + LW'(1);
						root_q  <= count_q;
					end else begin
						depth_q <= depth_m1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			value_q <= in_value;
			lo_q    <= cmd_item.range_low;
			hi_q    <= cmd_item.range_high;
		end
		if (cmd_fire) begin
			if (cmd_item.command == CMD_APPEND && is_full) begin
				res_q <= '{status: STS_FULL, result_value: '0};
			end else if (cmd_item.command == CMD_QUERY && !p_valid) begin
				res_q <= '{status: STS_NOTFOUND, result_value: -32'sd1};
			end else begin
				res_q <= '{status: STS_DONE, result_value: '0};
			end
		end else if (state_q == S_WALK && !p_valid) begin
			res_q <= '{status: STS_NOTFOUND, result_value: -32'sd1};
		end else if (state_q == S_QVAL) begin
			res_q <= '{status: STS_DONE, result_value: 32'(nv_rdata)};
		end
		if (state_q == S_POP_RD) begin
			t_q <= sp_rdata;
		end
		if ((cmd_fire && cmd_item.command == CMD_QUERY) || state_q == S_WALK) begin
			dir_q <= go_right;
		end
		if (state_q == S_RESULT && res_free) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	`ASSERT_NEXT(a_busy_after_transfer, clk, arst_n, cmd_fire, state_q != S_IDLE, "idle after transfer")
	`ASSERT_ALWAYS(a_spine_le_count, clk, arst_n, depth_q <= count_q, "spine deeper than tree")
	`ASSERT_ALWAYS(a_count_le_cap, clk, arst_n, count_q <= NULL_LINK, "node count past capacity")
	`ASSERT_ALWAYS(a_root_empty, clk, arst_n, (count_q == '0) == (root_q == NULL_LINK), "root and count disagree")
endmodule
`default_nettype wire

/* design/ctre_ram.sv */
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module ctre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

/* bench/cartesian_tree_range_extreme_core_tb.sv */
// Self-checking bench for the Cartesian tree range extreme core
`timescale 1ns / 1ps
module cartesian_tree_range_extreme_core_tb;
	import ctre_pkg::*;

	localparam int CAP = 1024;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic cmd_valid;
	logic cmd_stall;
	in_item_t cmd_item;
	logic rsp_valid;
	logic rsp_stall;
	out_item_t rsp_item;

	cartesian_tree_range_extreme_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_item(cmd_item),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item(rsp_item)
	);

	// shadow tree
	logic signed [31:0] tree_val [CAP];
	int unsigned tree_left [CAP];
	int unsigned tree_right [CAP];
	int unsigned spine [CAP];
	int unsigned spine_top;
	int unsigned tree_size;
	int unsigned tree_root;
	bit want_max;

	in_item_t pending_cmds[$];
	out_item_t awaited_rsps[$];
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_rsp;
	int hold_left;
	int mismatches;
	int idle_cycles;
	int cmds_sent;
	int rsps_seen;
	int queries_found;
	int full_refusals;

	function automatic bit beats(logic signed [31:0] a, logic signed [31:0] b);
		return want_max ? (a > b) : (a < b);
	endfunction

	function automatic out_item_t tree_apply(in_item_t c);
		out_item_t r;
		int unsigned n, t, p, steps;
		r.status = STS_DONE;
		r.result_value = '0;
		case (c.command)
			CMD_APPEND: begin
				if (tree_size >= CAP) begin
					r.status = STS_FULL;
				end else begin
					n = tree_size;
					while (spine_top > 0 && !beats(tree_val[spine[spine_top - 1]], c.new_value))
						spine_top--;
					tree_val[n] = c.new_value;
					tree_right[n] = CAP;
					if (spine_top == 0) begin
						tree_left[n] = tree_root;
						tree_root = n;
					end else begin
						t = spine[spine_top - 1];
						tree_left[n] = tree_right[t];
						tree_right[t] = n;
					end
					spine[spine_top] = n;
					spine_top++;
					tree_size = n + 1;
				end
			end
			CMD_QUERY: begin
				p = tree_root;
				steps = 0;
				r.status = STS_NOTFOUND;
				r.result_value = -1;
				while (p < CAP && p < tree_size && steps <= CAP) begin
					steps++;
					if (p < c.range_low) begin
						p = tree_right[p];
					end else if (c.range_high < p) begin
						p = tree_left[p];
					end else begin
						r.status = STS_DONE;
						r.result_value = tree_val[p];
						break;
					end
				end
			end
			CMD_CLEAR: begin
				spine_top = 0;
				tree_size = 0;
				tree_root = CAP;
			end
			default: ;
		endcase
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver
	logic cmd_taken;
	always @(posedge clk) begin
		if (arst_n && cmd_valid && !cmd_stall) begin
			cmd_taken <= 1'b1;
			awaited_rsps.push_back(tree_apply(cmd_item));
			cmds_sent++;
		end else begin
			cmd_taken <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (cmd_valid && !cmd_taken) begin
			// hold the offered transfer
		end else if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
			cmd_item <= pending_cmds.pop_front();
			cmd_valid <= 1'b1;
		end else begin
			cmd_valid <= 1'b0;
		end
		rsp_stall <= hold_rsp || ($urandom_range(99) < recv_stall_pct);
	end

	// long receiver hold-off, counted down here
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	always_comb hold_rsp = (hold_left > 0);

	// monitor
	always @(posedge clk) begin
		out_item_t exp_rsp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsps_seen++;
			if (awaited_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response status=%0d value=%0d",
						rsp_item.status, rsp_item.result_value);
			end else begin
				exp_rsp = awaited_rsps.pop_front();
				if (exp_rsp.status == STS_DONE && exp_rsp.result_value != 0)
					queries_found++;
				if (exp_rsp.status == STS_FULL)
					full_refusals++;
				if (rsp_item.status !== exp_rsp.status
						|| rsp_item.result_value !== exp_rsp.result_value) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected status=%0d value=%0d, got status=%0d value=%0d",
							exp_rsp.status, exp_rsp.result_value,
							rsp_item.status, rsp_item.result_value);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("cartesian_tree_range_extreme_core regression: fail");
			$finish;
		end
	end

	function automatic in_item_t make_cmd(logic [1:0] op, int v, int lo, int hi);
		in_item_t c;
		c.command = op;
		c.new_value = 32'(v);
		c.range_low = 10'(lo);
		c.range_high = 10'(hi);
		return c;
	endfunction

	function automatic in_item_t random_cmd(int fill);
		in_item_t c;
		int r, lo, hi;
		r = $urandom_range(99);
		c.new_value = $urandom;
		if ($urandom_range(3) == 0)
			c.new_value = $signed($urandom_range(15)) - 8;
		lo = $urandom_range(fill > 0 ? fill : 1);
		hi = lo + $urandom_range(fill > 0 ? fill : 1);
		if (hi > 1023) hi = 1023;
		c.range_low = 10'(lo);
		c.range_high = 10'(hi);
		if (r < 50) begin
			c.command = CMD_APPEND;
		end else if (r < 94) begin
			c.command = CMD_QUERY;
			if ($urandom_range(9) == 0) begin
				c.range_low = 10'($urandom);
				c.range_high = 10'($urandom);
			end
		end else if (r < 97) begin
			c.command = CMD_CLEAR;
		end else begin
			c.command = CMD_UNUSED;
		end
		return c;
	endfunction

	task automatic drain();
		while (pending_cmds.size() > 0 || cmd_valid || awaited_rsps.size() > 0)
			@(posedge clk);
		repeat (4000) @(posedge clk);
	endtask

	task automatic set_mode(bit m);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		want_max = m;
	endtask

	task automatic run_phase(int n, int idle_pct, int stall_pct, int fill);
		int k;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (k = 0; k < n; k++)
			pending_cmds.push_back(random_cmd(fill));
		drain();
	endtask

	initial begin
		int k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		cmd_valid = 1'b0;
		cmd_item = '0;
		rsp_stall = 1'b0;
		hold_left = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		idle_cycles = 0;
		cmds_sent = 0;
		rsps_seen = 0;
		queries_found = 0;
		full_refusals = 0;
		spine_top = 0;
		tree_size = 0;
		tree_root = CAP;
		want_max = 1'b0;
		cmd_taken = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty tree, extremes, equal values, inverted range, unused code
		pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 1023));
		pending_cmds.push_back(make_cmd(CMD_APPEND, 32'sh7fffffff, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_APPEND, 32'sh80000000, 1023, 1023));
		pending_cmds.push_back(make_cmd(CMD_APPEND, 5, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_APPEND, 5, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_APPEND, -1, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 1023));
		pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 2, 3));
		pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 3, 4));
		pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 4, 1));
		pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 1023, 1023));
		pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_UNUSED, -1, 1023, 1023));
		pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 1023));
		drain();

		// fill to capacity in max mode, then refuse; ascending values keep spine short
		set_mode(1'b1);
		for (k = 0; k < CAP; k++)
			pending_cmds.push_back(make_cmd(CMD_APPEND, k - 512, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_APPEND, 0, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 100, 900));
		pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 1023));
		pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0));
		drain();

		run_phase(50, 0, 0, 60);
		set_mode(1'b0);
		run_phase(60, 46, 0, 60);
		set_mode(1'b1);
		run_phase(60, 0, 46, 120);
		set_mode(1'b0);
		run_phase(60, 13, 13, 200);

		// long receiver hold-off while commands keep coming
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (k = 0; k < 30; k++)
			pending_cmds.push_back(random_cmd(80));
		@(negedge clk);
		hold_left = 3000;
		wait (hold_left == 0);
		drain();

		set_mode(1'b1);
		run_phase(50, 0, 0, 80);

		$display("covered %0d commands, %0d responses: %0d found queries, %0d full refusals,",
			cmds_sent, rsps_seen, queries_found, full_refusals);
		$display("both ordering modes, stalls on both sides and a long response hold-off");
		if (mismatches == 0 && awaited_rsps.size() == 0)
			$display("cartesian_tree_range_extreme_core regression: pass");
		else
			$display("cartesian_tree_range_extreme_core regression: fail");
		$finish;
	end
endmodule
